@@ rtl/gcdl_pkg.sv @@
// Package with item types, state codes and shared constants for the GCD/LCM unit.
package gcdl_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned ProdWidth = 64;

  typedef struct packed {
    logic [DataWidth-1:0] operand_a;
    logic [DataWidth-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] divisor;
    logic [ProdWidth-1:0] multiple;
    logic                 zero_operand;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EUC_START,
    S_EUC_WAIT,
    S_QUO_START,
    S_QUO_WAIT,
    S_MUL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/gcd_lcm_unit.sv @@
// Top level of the GCD/LCM unit: sequencer, divider instance, shift-add multiplier and output register.
//
//   channel | direction | handshake                | payload
//   in      | in        | in_valid_i / in_stall_o  | in_data_i  (operand_a, operand_b)
//   out     | out       | out_valid_o / out_stall_i| out_data_o (divisor, multiple, zero_operand)
//
// One item at a time. Each Euclid remainder step runs in the shared bit-serial
// divider, then a/gcd runs in it as well, and the shift-add multiply takes that
// quotient times b. A zero operand skips the divider and the multiplier. Reset
// clears the sequencer and the output valid; the next item is taken while a
// finished result waits under out_stall_i.
module gcd_lcm_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gcdl_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gcdl_pkg::out_item_t out_data_o
);
  import gcdl_pkg::*;

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned CntW = $clog2(W + 1);

  state_e          state_q, state_d;
  logic [W-1:0]    x_q, y_q, a_q, b_q, g_q, mplier_q;
  logic [2*W-1:0]  mcand_q, acc_q;
  logic [CntW-1:0] mcnt_q;
  logic            err_q;
  logic            out_valid_q;
  out_item_t       out_q;

  logic            in_fire, out_fire, fin_load;
  logic [W-1:0]    op_a, op_b;
  logic            div_start;
  logic [W-1:0]    div_dividend, div_divisor, div_quo, div_rem;
  div_stat_t       div_stat;

  assign op_a     = in_data_i.operand_a[W-1:0];
  assign op_b     = in_data_i.operand_b[W-1:0];
  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign out_fire = out_valid_q && !out_stall_i;
  assign fin_load = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  assign div_start    = (state_q == S_EUC_START) || (state_q == S_QUO_START);
  assign div_dividend = (state_q == S_QUO_START) ? a_q : x_q;
  assign div_divisor  = (state_q == S_QUO_START) ? g_q : y_q;

  gcdl_div #(
    .W (W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .stat_o      (div_stat),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (op_a == '0 || op_b == '0) ? S_FIN : S_EUC_START;
        end
      end
      S_EUC_START: state_d = S_EUC_WAIT;
      S_EUC_WAIT: begin
        if (div_stat.done) begin
          state_d = (div_rem == '0) ? S_QUO_START : S_EUC_START;
        end
      end
      S_QUO_START: state_d = S_QUO_WAIT;
      S_QUO_WAIT: begin
        if (div_stat.done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (mcnt_q == CntW'(1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q   <= op_a;
      b_q   <= op_b;
      x_q   <= (op_a < op_b) ? op_b : op_a;
      y_q   <= (op_a < op_b) ? op_a : op_b;
      g_q   <= '0;
      acc_q <= '0;
      err_q <= (op_a == '0 || op_b == '0);
    end
    if (state_q == S_EUC_WAIT && div_stat.done) begin
      if (div_rem == '0) begin
        g_q <= y_q;
      end else begin
        x_q <= y_q;
        y_q <= div_rem;
      end
    end
    if (state_q == S_QUO_WAIT && div_stat.done) begin
      mplier_q <= div_quo;
      mcand_q  <= {{W{1'b0}}, b_q};
      acc_q    <= '0;
      mcnt_q   <= CntW'(W);
    end
    if (state_q == S_MUL) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[2*W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[W-1:1]};
      mcnt_q   <= mcnt_q - 1'b1;
    end
    if (fin_load) begin
      out_q.divisor      <= DataWidth'(g_q);
      out_q.multiple     <= ProdWidth'(acc_q);
      out_q.zero_operand <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_operand |->
      out_data_o.divisor == '0 && out_data_o.multiple == '0)
    else $error("error result carries nonzero values");

  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.zero_operand |-> out_data_o.divisor != '0)
    else $error("valid result with zero divisor");

  a_load_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("output loaded outside finish state");
`endif

endmodule

@@ rtl/gcdl_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all divisions of an item.
module gcdl_div #(
  parameter int unsigned W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [W-1:0]        dividend_i,
  input  logic [W-1:0]        divisor_i,
  output gcdl_pkg::div_stat_t stat_o,
  output logic [W-1:0]        quotient_o,
  output logic [W-1:0]        remainder_o
);
  import gcdl_pkg::*;

  localparam int unsigned CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt_q;
  logic            done_q;
  logic [W:0]      rem_q;
  logic [W-1:0]    quo_q;
  logic [W-1:0]    dsr_q;

  logic [W:0]      shifted;
  logic [W+1:0]    diff;
  logic            ge;

  assign shifted = {rem_q[W-1:0], quo_q[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign ge      = ~diff[W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CntW'(W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CntW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[W:0] : shifted;
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign stat_o.busy  = (cnt_q != '0);
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q[W-1:0];

endmodule
